// ===== sv/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, codes and constants for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

  // default geometry
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int WAYS_DEF         = 8;

  // front-to-back queue depth
  localparam int QUEUE_DEPTH = 2;

  // field widths
  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 32;
  localparam int OUTCOME_W = 2;
  localparam int TOTAL_W   = 32;
  localparam int TAG_W     = 32;

  // configuration register widths and limits
  localparam int SETB_W         = 3;
  localparam int BLKB_W         = 5;
  localparam int WAYSU_W        = 4;
  localparam int MAX_BLOCK_BITS = 16;

  // APB
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register indexes
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  // register reset values
  localparam logic [SETB_W-1:0]  SET_BITS_RST    = 3'd4;
  localparam logic [BLKB_W-1:0]  BLOCK_BITS_RST  = 5'd4;
  localparam logic [WAYSU_W-1:0] WAYS_IN_USE_RST = 4'd1;

  // access kinds
  localparam logic [MODE_W-1:0] MODE_FETCH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd3;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic [SETB_W-1:0]  set_bits;
    logic [BLKB_W-1:0]  block_bits;
    logic [WAYSU_W-1:0] ways_in_use;
  } salc_cfg_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_READ,
    BK_EXEC,
    BK_SECOND
  } salc_bk_state_t;

endpackage

`default_nettype wire

// ===== sv/salc_in_if.sv =====
// ----------------------------------------------------------------------------
// salc_in_if
// Access channel: one beat carries an access kind and a byte address.
// ----------------------------------------------------------------------------
`default_nettype none

interface salc_in_if;
  import salc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] address;

  modport source(output valid, output mode, output address, input ready);
  modport sink(input valid, input mode, input address, output ready);

endinterface

`default_nettype wire

// ===== sv/salc_out_if.sv =====
// ----------------------------------------------------------------------------
// salc_out_if
// Result channel: one beat carries an outcome and the running totals.
// ----------------------------------------------------------------------------
`default_nettype none

interface salc_out_if;
  import salc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [TOTAL_W-1:0]   hit_total;
  logic [TOTAL_W-1:0]   miss_total;
  logic [TOTAL_W-1:0]   eviction_total;
  logic                 last;

  modport source(output valid, output outcome, output hit_total, output miss_total,
                 output eviction_total, output last, input ready);
  modport sink(input valid, input outcome, input hit_total, input miss_total,
               input eviction_total, input last, output ready);

endinterface

`default_nettype wire

// ===== sv/salc_front.sv =====
// ----------------------------------------------------------------------------
// salc_front
// Accepts accesses, drops instruction fetches, splits the address into tag
// and set and pushes the lookup into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_front #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int ENT_W        = 1 + salc_pkg::TAG_W + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)
) (
  input  wire salc_pkg::salc_cfg_t cfg,
  input  wire                      clearing,
  salc_in_if.sink                  req,
  output logic                     push_valid,
  input  wire                      push_ready,
  output logic [ENT_W-1:0]         push_data
);
  import salc_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  logic [4:0]        s_eff;
  logic [4:0]        b_eff;
  logic [5:0]        tag_sh;
  logic [TAG_W-1:0]  tag;
  logic [ADDR_W-1:0] set_full;
  logic [ADDR_W-1:0] set_mask;
  logic [SET_W-1:0]  set_idx;
  logic              is_mod;

  always_comb begin
    s_eff = (int'(cfg.set_bits) > MAX_SET_BITS) ? 5'(MAX_SET_BITS) : 5'(cfg.set_bits);
    b_eff = (int'(cfg.block_bits) > MAX_BLOCK_BITS) ? 5'(MAX_BLOCK_BITS) : cfg.block_bits;
    tag_sh   = 6'(s_eff) + 6'(b_eff);
    tag      = req.address >> tag_sh;
    set_full = req.address >> b_eff;
    set_mask = ~({ADDR_W{1'b1}} << s_eff);
    set_idx  = SET_W'(set_full & set_mask);
    is_mod   = (req.mode == MODE_MODIFY);
  end

  // fetches are taken and dropped, but like everything else wait for a queue slot
  assign req.ready  = push_ready & ~clearing;
  assign push_valid = req.valid & ~clearing & (req.mode != MODE_FETCH);
  assign push_data  = {is_mod, tag, set_idx};

endmodule

`default_nettype wire

// ===== sv/salc_queue.sv =====
// ----------------------------------------------------------------------------
// salc_queue
// Small FIFO that decouples the front from the lookup engine.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = salc_pkg::QUEUE_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push_valid,
  output logic             push_ready,
  input  wire [WIDTH-1:0]  push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/salc_back.sv =====
// ----------------------------------------------------------------------------
// salc_back
// Lookup engine: reads one set row, resolves hit, fill or eviction, updates
// the LRU ranks, writes the row back and issues the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_back #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS         = salc_pkg::WAYS_DEF,
  parameter int ENT_W        = 1 + salc_pkg::TAG_W + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire salc_pkg::salc_cfg_t cfg,
  output logic                     clearing,
  input  wire                      pop_valid,
  output logic                     pop_ready,
  input  wire [ENT_W-1:0]          pop_data,
  salc_out_if.source               rsp
);
  import salc_pkg::*;

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W   = $clog2(WAYS + 1);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

  // set memory: one row per set, all ways side by side
  logic [WAYS-1:0]              mem_vld  [NUM_SETS];
  logic [WAYS-1:0][TAG_W-1:0]   mem_tag  [NUM_SETS];
  logic [WAYS-1:0][RANK_W-1:0]  mem_rank [NUM_SETS];

  logic [WAYS-1:0]              row_vld;
  logic [WAYS-1:0][TAG_W-1:0]   row_tag;
  logic [WAYS-1:0][RANK_W-1:0]  row_rank;

  logic [WAYS-1:0]              new_vld;
  logic [WAYS-1:0][TAG_W-1:0]   new_tag;
  logic [WAYS-1:0][RANK_W-1:0]  new_rank;

  salc_bk_state_t state, state_next;
  logic [SET_W-1:0] clr_cnt;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;
  logic             cur_mod;

  logic [TOTAL_W-1:0] hits, misses, evictions;
  logic [TOTAL_W-1:0] hits_next, misses_next, evictions_next;

  logic                 out_valid;
  logic [OUTCOME_W-1:0] out_outcome;
  logic                 out_last;
  logic                 out_free;

  logic mem_re;
  logic upd_we;
  logic clr_we;
  logic load_out;
  logic res_last;
  logic [OUTCOME_W-1:0] res_outcome;
  logic hit_inc, miss_inc, evict_inc;

  // lookup results
  logic [WCNT_W-1:0]    ways_eff;
  logic [WAYS-1:0]      in_use;
  logic                 hit_found;
  logic                 free_found;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     free_way;
  logic [WAY_W-1:0]     old_way;
  logic [WAY_W-1:0]     pick;
  logic [RANK_W-1:0]    best;
  logic [RANK_W-1:0]    hit_rank;
  logic [OUTCOME_W-1:0] lk_outcome;

  assign out_free = ~out_valid | rsp.ready;
  assign clearing = (state == BK_CLEAR);

  // ---------------- lookup ----------------
  always_comb begin
    if (cfg.ways_in_use == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(cfg.ways_in_use) > WAYS) begin
      ways_eff = WCNT_W'(WAYS);
    end else begin
      ways_eff = WCNT_W'(cfg.ways_in_use);
    end

    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    best       = '0;
    old_way    = '0;
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (w < int'(ways_eff));
      if (!hit_found && in_use[w] && row_vld[w] && row_tag[w] == cur_tag) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (!free_found && in_use[w] && !row_vld[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
      // every way in use is valid when this one matters
      if (in_use[w] && row_rank[w] > best) begin
        best    = row_rank[w];
        old_way = WAY_W'(w);
      end
    end

    if (hit_found) begin
      pick       = hit_way;
      lk_outcome = OUT_HIT;
    end else if (free_found) begin
      pick       = free_way;
      lk_outcome = OUT_FILL;
    end else begin
      pick       = old_way;
      lk_outcome = OUT_EVICT;
    end
    hit_rank = row_rank[pick];

    new_vld  = row_vld;
    new_tag  = row_tag;
    new_rank = row_rank;
    for (int w = 0; w < WAYS; w++) begin
      // on a hit only lines fresher than the hit line age
      if (in_use[w] && row_vld[w] && WAY_W'(w) != pick &&
          (!hit_found || row_rank[w] < hit_rank) && row_rank[w] < RANK_MAX) begin
        new_rank[w] = row_rank[w] + 1'b1;
      end
    end
    new_vld[pick]  = 1'b1;
    new_tag[pick]  = cur_tag;
    new_rank[pick] = '0;
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pop_ready   = 1'b0;
    mem_re      = 1'b0;
    upd_we      = 1'b0;
    clr_we      = 1'b0;
    load_out    = 1'b0;
    res_outcome = OUT_HIT;
    res_last    = 1'b1;
    hit_inc     = 1'b0;
    miss_inc    = 1'b0;
    evict_inc   = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        clr_we = 1'b1;
        if (clr_cnt == SET_W'(NUM_SETS - 1)) begin
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          mem_re     = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        res_outcome = lk_outcome;
        res_last    = ~cur_mod;
        hit_inc     = (lk_outcome == OUT_HIT);
        miss_inc    = (lk_outcome != OUT_HIT);
        evict_inc   = (lk_outcome == OUT_EVICT);
        if (out_free) begin
          load_out   = 1'b1;
          upd_we     = 1'b1;
          state_next = cur_mod ? BK_SECOND : BK_READ;
        end
      end
      BK_SECOND: begin
        // the store half of a modify always hits the line just touched
        hit_inc = 1'b1;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = BK_READ;
        end
      end
      default: begin
        state_next = BK_READ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clr_we) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // ---------------- set memory ----------------
  always_ff @(posedge clk) begin
    if (clr_we) begin
      mem_vld[clr_cnt] <= '0;
    end else if (upd_we) begin
      mem_vld[cur_set]  <= new_vld;
      mem_tag[cur_set]  <= new_tag;
      mem_rank[cur_set] <= new_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      row_vld  <= mem_vld[pop_data[SET_W-1:0]];
      row_tag  <= mem_tag[pop_data[SET_W-1:0]];
      row_rank <= mem_rank[pop_data[SET_W-1:0]];
      cur_set  <= pop_data[SET_W-1:0];
      cur_tag  <= pop_data[SET_W +: TAG_W];
      cur_mod  <= pop_data[ENT_W-1];
    end
  end

  // ---------------- totals and result beat ----------------
  assign hits_next      = hits + TOTAL_W'(hit_inc);
  assign misses_next    = misses + TOTAL_W'(miss_inc);
  assign evictions_next = evictions + TOTAL_W'(evict_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      hits      <= '0;
      misses    <= '0;
      evictions <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        hits      <= hits_next;
        misses    <= misses_next;
        evictions <= evictions_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_outcome <= res_outcome;
      out_last    <= res_last;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.outcome        = out_outcome;
  assign rsp.hit_total      = hits;
  assign rsp.miss_total     = misses;
  assign rsp.eviction_total = evictions;
  assign rsp.last           = out_last;

endmodule

`default_nettype wire

// ===== sv/set_associative_lru_cache_sim_top.sv =====
// ----------------------------------------------------------------------------
// set_associative_lru_cache_sim_top
// Set-associative cache simulator with exact LRU ranks and running totals.
// ----------------------------------------------------------------------------
// Each access beat on req is split into tag and set with the configured set
// and block bit counts; fetches are taken and produce nothing, loads and
// stores produce one result beat, a modify produces two (last marks the
// final one). A load or store has the lookup engine read the set row from
// the single-port set memory, then resolve the hit or replacement and write
// the row back; a modify then issues its store-half beat too. A two-entry
// queue between the front and the engine, and a result register before rsp,
// let both sides stall on their own. After reset the set memory is cleared
// one row per cycle, all 2**MAX_SET_BITS rows, during which req is not ready;
// configuration writes are taken at any time but must only change while
// the block is idle.
`default_nettype none

module set_associative_lru_cache_sim_top #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS         = salc_pkg::WAYS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  salc_in_if.sink                         req,
  salc_out_if.source                      rsp,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [salc_pkg::PADDR_W-1:0]     paddr,
  input  wire [salc_pkg::PDATA_W-1:0]     pwdata,
  output logic [salc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import salc_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ENT_W = 1 + TAG_W + SET_W;

  salc_cfg_t        cfg;
  logic             wr_en;
  logic [1:0]       reg_idx;
  logic             clearing;
  logic             push_valid, push_ready;
  logic [ENT_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [ENT_W-1:0] pop_data;

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits    <= SET_BITS_RST;
      cfg.block_bits  <= BLOCK_BITS_RST;
      cfg.ways_in_use <= WAYS_IN_USE_RST;
    end else if (wr_en) begin
      if (reg_idx == REG_SET_BITS) begin
        cfg.set_bits <= pwdata[SETB_W-1:0];
      end else if (reg_idx == REG_BLOCK_BITS) begin
        cfg.block_bits <= pwdata[BLKB_W-1:0];
      end else if (reg_idx == REG_WAYS_IN_USE) begin
        cfg.ways_in_use <= pwdata[WAYSU_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SET_BITS:    prdata = PDATA_W'(cfg.set_bits);
      REG_BLOCK_BITS:  prdata = PDATA_W'(cfg.block_bits);
      REG_WAYS_IN_USE: prdata = PDATA_W'(cfg.ways_in_use);
      default:         prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  salc_front #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .ENT_W       (ENT_W)
  ) u_front (
    .cfg       (cfg),
    .clearing  (clearing),
    .req       (req),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  salc_queue #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  salc_back #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .WAYS        (WAYS),
    .ENT_W       (ENT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

// ===== dv/cache_outcome_checker.sv =====
// ----------------------------------------------------------------------------
// cache_outcome_checker
// Watches the access, result and register ports of the LRU cache block.
// It keeps its own copy of the cache lines and the totals, predicts the
// outcome beats for each access it sees accepted, and compares every result
// beat in order with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cache_outcome_checker
  import salc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  salc_in_if                  req,
  salc_out_if                 rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output int                  mismatches,
  output int                  beats_due
);

  localparam int SETS      = 1 << MAX_SET_BITS_DEF;
  localparam int LINES     = SETS * WAYS_DEF;
  localparam int RANK_W    = (WAYS_DEF > 1) ? $clog2(WAYS_DEF) : 1;
  localparam int RANK_MAX  = WAYS_DEF - 1;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [TOTAL_W-1:0]   hit_total;
    logic [TOTAL_W-1:0]   miss_total;
    logic [TOTAL_W-1:0]   eviction_total;
    logic                 last;
  } outcome_beat_t;

  outcome_beat_t         due_outcomes[$];

  logic                  line_live[LINES];
  logic [TAG_W-1:0]      line_tag[LINES];
  logic [RANK_W-1:0]     line_rank[LINES];
  logic [TOTAL_W-1:0]    hit_cnt;
  logic [TOTAL_W-1:0]    miss_cnt;
  logic [TOTAL_W-1:0]    evict_cnt;
  salc_cfg_t             cfg;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic bump_rank(input int idx);
    if (line_rank[idx] < RANK_MAX[RANK_W-1:0])
      line_rank[idx] = line_rank[idx] + 1'b1;
  endtask

  // one lookup of the cache; a modify calls this twice
  task automatic lookup_line(input logic [ADDR_W-1:0] addr, input logic closing);
    int                   sb;
    int                   bb;
    int                   nw;
    int                   base;
    int                   pick;
    int                   w;
    logic [TAG_W-1:0]     tg;
    logic [RANK_W-1:0]    r;
    logic [RANK_W-1:0]    best;
    logic [OUTCOME_W-1:0] oc;
    outcome_beat_t        beat;
    sb = (cfg.set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(cfg.set_bits);
    bb = (cfg.block_bits > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : int'(cfg.block_bits);
    nw = (cfg.ways_in_use == 0) ? 1 :
         ((cfg.ways_in_use > WAYS_DEF) ? WAYS_DEF : int'(cfg.ways_in_use));
    tg   = addr >> (sb + bb);
    base = int'((addr >> bb) & ((32'd1 << sb) - 32'd1)) * WAYS_DEF;
    pick = WAYS_DEF;
    for (w = 0; w < nw; w++)
      if (pick == WAYS_DEF && line_live[base + w] && line_tag[base + w] == tg)
        pick = w;
    if (pick < nw) begin
      r = line_rank[base + pick];
      for (w = 0; w < nw; w++)
        if (w != pick && line_live[base + w] && line_rank[base + w] < r)
          bump_rank(base + w);
      line_rank[base + pick] = '0;
      hit_cnt = hit_cnt + 1'b1;
      oc = OUT_HIT;
    end else begin
      for (w = 0; w < nw; w++)
        if (pick == WAYS_DEF && !line_live[base + w])
          pick = w;
      if (pick < nw) begin
        oc = OUT_FILL;
      end else begin
        // all ways live: oldest rank loses, lowest way on ties
        best = '0;
        pick = 0;
        for (w = 0; w < nw; w++)
          if (line_rank[base + w] > best) begin
            best = line_rank[base + w];
            pick = w;
          end
        evict_cnt = evict_cnt + 1'b1;
        oc = OUT_EVICT;
      end
      for (w = 0; w < nw; w++)
        if (w != pick && line_live[base + w])
          bump_rank(base + w);
      line_live[base + pick] = 1'b1;
      line_tag[base + pick]  = tg;
      line_rank[base + pick] = '0;
      miss_cnt = miss_cnt + 1'b1;
    end
    beat.outcome        = oc;
    beat.hit_total      = hit_cnt;
    beat.miss_total     = miss_cnt;
    beat.eviction_total = evict_cnt;
    beat.last           = closing;
    due_outcomes.push_back(beat);
  endtask

  task automatic compare_beat();
    outcome_beat_t want;
    if (due_outcomes.size() == 0) begin
      report_mismatch("unexpected beat, outcome", rsp.outcome, '0);
      return;
    end
    want = due_outcomes.pop_front();
    if (rsp.outcome !== want.outcome)
      report_mismatch("outcome", rsp.outcome, want.outcome);
    if (rsp.hit_total !== want.hit_total)
      report_mismatch("hit_total", rsp.hit_total, want.hit_total);
    if (rsp.miss_total !== want.miss_total)
      report_mismatch("miss_total", rsp.miss_total, want.miss_total);
    if (rsp.eviction_total !== want.eviction_total)
      report_mismatch("eviction_total", rsp.eviction_total, want.eviction_total);
    if (rsp.last !== want.last)
      report_mismatch("last", rsp.last, want.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        line_live[i] = 1'b0;
        line_tag[i]  = '0;
        line_rank[i] = '0;
      end
      hit_cnt   = '0;
      miss_cnt  = '0;
      evict_cnt = '0;
      cfg.set_bits    = SET_BITS_RST;
      cfg.block_bits  = BLOCK_BITS_RST;
      cfg.ways_in_use = WAYS_IN_USE_RST;
      due_outcomes.delete();
      mismatches = 0;
    end else begin
      if (rsp.valid && rsp.ready)
        compare_beat();
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SET_BITS:    cfg.set_bits    = pwdata[SETB_W-1:0];
          REG_BLOCK_BITS:  cfg.block_bits  = pwdata[BLKB_W-1:0];
          REG_WAYS_IN_USE: cfg.ways_in_use = pwdata[WAYSU_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        case (req.mode)
          MODE_LOAD, MODE_STORE: lookup_line(req.address, 1'b1);
          MODE_MODIFY: begin
            lookup_line(req.address, 1'b0);
            lookup_line(req.address, 1'b1);
          end
          default: ;
        endcase
      end
    end
    beats_due = due_outcomes.size();
  end

endmodule

// ===== dv/tb_set_associative_lru_cache_sim_top.sv =====
// ----------------------------------------------------------------------------
// tb_set_associative_lru_cache_sim_top
// Stimulus and verdict for the set-associative LRU cache block.
// A short directed run at the reset geometry and at one fully associative
// set, then phases of random accesses under many geometries, extremes and
// out-of-range register values among them. Addresses mostly come from a
// small tag pool over a few sets so hits and evictions are frequent. Both
// channels stall at random; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_set_associative_lru_cache_sim_top;
  import salc_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PHASE_ITEMS   = 140;
  localparam int PHASES        = 12;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  int                  mismatches;
  int                  beats_due;

  logic                tx_calm = 1'b0;
  logic                rx_calm = 1'b0;
  int                  rx_wait = 0;
  int unsigned         cur_set;
  int unsigned         cur_blk;
  logic [31:0]         tag_pool[16];
  int                  pool_n;

  // fixed geometries first: extremes, saturating values, zero ways
  int unsigned         fix_set[8]  = '{0, 6, 7, 2, 1, 3, 6, 0};
  int unsigned         fix_blk[8]  = '{0, 16, 31, 5, 3, 2, 0, 16};
  int unsigned         fix_ways[8] = '{1, 8, 15, 0, 4, 8, 2, 8};

  salc_in_if  req_if();
  salc_out_if rsp_if();

  set_associative_lru_cache_sim_top DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cache_outcome_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .beats_due  (beats_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall before each beat
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_wait > 0) begin
        rsp_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
      @(posedge clk);
      if (rsp_if.ready && rsp_if.valid)
        rx_wait = rx_calm ? 0 : $urandom_range(0, 13);
    end
  end

  // entered and left at a falling edge with nothing yet assigned there
  task automatic send_access(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.mode    <= m;
    req_if.address <= a;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    // a fetch leaves no beat to wait for, since the front drops it
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input int unsigned s, input int unsigned b,
                              input int unsigned nw);
    int eff;
    wait_drained();
    reg_write(REG_SET_BITS, s);
    reg_write(REG_BLOCK_BITS, b);
    reg_write(REG_WAYS_IN_USE, nw);
    cur_set  = s;
    cur_blk  = b;
    eff = (nw == 0) ? 1 : ((nw > WAYS_DEF) ? WAYS_DEF : nw);
    // a couple more tags than ways so sets keep overflowing
    pool_n = eff + 2;
    for (int i = 0; i < pool_n; i++)
      tag_pool[i] = $urandom_range(0, 1) ? i : $urandom();
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int          sb;
    int          bb;
    logic [31:0] tg;
    logic [31:0] st;
    logic [31:0] off;
    sb = (cur_set > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cur_set;
    bb = (cur_blk > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : cur_blk;
    if ($urandom_range(0, 9) == 0)
      return $urandom();
    tg  = tag_pool[$urandom_range(0, pool_n - 1)];
    st  = $urandom_range(0, 3) & ((32'd1 << sb) - 32'd1);
    off = $urandom() & ((32'd1 << bb) - 32'd1);
    return (tg << (sb + bb)) | (st << bb) | off;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0)
      return MODE_FETCH;
    else if (r <= 3)
      return MODE_LOAD;
    else if (r <= 5)
      return MODE_STORE;
    else
      return MODE_MODIFY;
  endfunction

  initial begin
    int guard;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_if.valid   = 1'b0;
    req_if.mode    = MODE_FETCH;
    req_if.address = '0;
    cur_set        = SET_BITS_RST;
    cur_blk        = BLOCK_BITS_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset geometry: 16 sets, 16-byte blocks, direct mapped
    send_access(MODE_LOAD,   32'h0000_0000);
    send_access(MODE_LOAD,   32'h0000_000F);
    send_access(MODE_STORE,  32'h0000_0010);
    send_access(MODE_MODIFY, 32'h0000_0100);
    send_access(MODE_FETCH,  32'hFFFF_FFFF);
    send_access(MODE_LOAD,   32'hFFFF_FFFF);
    send_access(MODE_STORE,  32'hFFFF_FFF0);
    send_access(MODE_MODIFY, 32'h0000_0000);
    send_access(MODE_LOAD,   32'hAAAA_AAAA);
    send_access(MODE_STORE,  32'h5555_5555);
    send_access(MODE_MODIFY, 32'hAAAA_AAAA);
    send_access(MODE_FETCH,  32'h1234_5678);

    // one set, eight ways: fill, overflow into LRU eviction, then hit
    set_geometry(0, 0, 8);
    for (int i = 1; i <= 9; i++)
      send_access(MODE_LOAD, i);
    send_access(MODE_LOAD, 32'd2);
    send_access(MODE_MODIFY, 32'd1);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 8)
        set_geometry(fix_set[p], fix_blk[p], fix_ways[p]);
      else
        set_geometry($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 15));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        if (n == PHASE_ITEMS / 2)
          wait_drained();
        send_access(pick_mode(), pick_address());
      end
    end

    req_if.valid <= 1'b0;
    guard = 0;
    while (beats_due != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (beats_due != 0)
      $display("%0d expected results never arrived", beats_due);
    if (mismatches == 0 && beats_due == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
